// ===== hw/rtl/lap3_pkg.sv =====
// Shared types and constants for the 3x3 Laplacian stream filter.
package lap3_pkg;

  // Field widths fixed by the stream and register formats
  localparam int PIXEL_IN_BITS  = 8;
  localparam int FILT_BITS      = 11;
  localparam int CFG_WIDTH_BITS = 11;
  localparam int CFG_HGT_BITS   = 16;
  localparam int CFG_ADDR_BITS  = 3;
  localparam int CFG_DATA_BITS  = 32;

  // Register indexes (paddr bit 2)
  localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

  // Register reset values
  localparam logic [CFG_WIDTH_BITS-1:0] WIDTH_RESET  = 11'd6;
  localparam logic [CFG_HGT_BITS-1:0]   HEIGHT_RESET = 16'd6;

  // Input word
  typedef struct packed {
    logic [PIXEL_IN_BITS-1:0] pixel;
    logic                     frame_start;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic signed [FILT_BITS-1:0] filtered;
    logic                        last;
  } out_word_t;

  // Register file contents handed to the datapath
  typedef struct packed {
    logic [CFG_WIDTH_BITS-1:0] image_width;
    logic [CFG_HGT_BITS-1:0]   image_height;
  } cfg_regs_t;

endpackage

// ===== hw/rtl/lap3_cfg.sv =====
// APB register file holding image width and height.
module lap3_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lap3_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [lap3_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [lap3_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                                pready,
  output lap3_pkg::cfg_regs_t                 regs
);
  import lap3_pkg::*;

  logic [CFG_WIDTH_BITS-1:0] width_r, width_nxt;
  logic [CFG_HGT_BITS-1:0]   height_r, height_nxt;
  logic                      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Decode the write in the access phase
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (wr_en) begin
      case (paddr[2])
        REG_IMAGE_WIDTH:  width_nxt  = pwdata[CFG_WIDTH_BITS-1:0];
        REG_IMAGE_HEIGHT: height_nxt = pwdata[CFG_HGT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  // Read back the selected register
  always_comb begin
    case (paddr[2])
      REG_IMAGE_WIDTH:  prdata = {{(CFG_DATA_BITS-CFG_WIDTH_BITS){1'b0}}, width_r};
      REG_IMAGE_HEIGHT: prdata = {{(CFG_DATA_BITS-CFG_HGT_BITS){1'b0}}, height_r};
      default:          prdata = '0;
    endcase
  end

  assign regs.image_width  = width_r;
  assign regs.image_height = height_r;

endmodule

// ===== hw/rtl/lap3_line_store.sv =====
// One line of pixel storage: registered read, write-first on address match.
module lap3_line_store #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read port, forward a same-cycle write to the same entry
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/lap3_col_cell.sv =====
// One window column (top, middle, bottom), passed to the next cell on shift.
module lap3_col_cell #(
  parameter int PB = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift_en,
  input  logic [PB-1:0] top_in,
  input  logic [PB-1:0] mid_in,
  input  logic [PB-1:0] bot_in,
  output logic [PB-1:0] top_out,
  output logic [PB-1:0] mid_out,
  output logic [PB-1:0] bot_out
);

  logic [PB-1:0] top_r, mid_r, bot_r;

  // Load the column from the neighbor on each shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= '0;
      mid_r <= '0;
      bot_r <= '0;
    end else if (shift_en) begin
      top_r <= top_in;
      mid_r <= mid_in;
      bot_r <= bot_in;
    end
  end

  assign top_out = top_r;
  assign mid_out = mid_r;
  assign bot_out = bot_r;

endmodule

// ===== hw/rtl/laplacian_3x3_stream_filter.sv =====
// Top level of the four-neighbor 3x3 Laplacian stream filter.
// Usage:
//   in_valid/in_ready carry one pixel word per handshake in raster order;
//   frame_start set on a word restarts the position at row 0, column 0.
//   out_valid/out_ready carry one result word per interior pixel:
//   filtered = 4*center - up - down - left - right, and last marks the
//   result at row height-2, column width-2. Border pixels give no word.
//   The APB port (psel .. pready) sets image_width at 0x0 and image_height
//   at 0x4; write them only while the stream is idle.
// Timing:
//   One word per cycle sustained while out_ready is high. An accepted word
//   reads both line stores and enters the second stage, whose result goes
//   to the result register behind out_valid. The single line-store read
//   port per line and the window shift set that one-word-per-cycle figure.
// Reset and stall:
//   Reset clears the position, window and valid flags; the line stores
//   keep their contents, and stale entries never reach a result word.
//   A stalled receiver holds the result register; the block keeps taking
//   words until the stage in front of it is full, then drops in_ready.
module laplacian_3x3_stream_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  lap3_pkg::in_word_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output lap3_pkg::out_word_t                 out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lap3_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [lap3_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [lap3_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                                pready
);
  import lap3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int PB = PIXEL_BITS;
  localparam int SW = (PB + 4 > FILT_BITS) ? PB + 4 : FILT_BITS;

  cfg_regs_t regs;

  // Effective geometry
  logic [31:0]             w_ext, w_eff, w_last_full;
  logic [CW-1:0]           w_last;
  logic [CFG_HGT_BITS-1:0] h_eff, h_last;

  // Position and first stage
  logic [CW-1:0]           col_r, col_nxt, col_cur;
  logic [CFG_HGT_BITS-1:0] row_r, row_nxt, row_cur;
  logic                    accept;
  logic [15:0]             pix_ext;
  logic [PB-1:0]           pix_in;

  // Second stage
  logic                    b_valid_r, b_valid_nxt;
  logic                    b_emit_r, b_last_r;
  logic [CW-1:0]           b_idx_r;
  logic [PB-1:0]           b_px_r;
  logic                    b_adv;

  // Line store and window taps
  logic [PB-1:0]           up_rd, lo_rd;
  logic [PB-1:0]           w0_top, w0_mid, w0_bot, w1_mid;

  // Result register
  logic                    out_free;
  logic                    out_valid_r, out_valid_nxt;
  out_word_t               out_data_r;
  logic [SW-1:0]           sum;

  lap3_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .regs    (regs)
  );

  // Clamp width and height into their legal ranges
  always_comb begin
    w_ext = {{(32-CFG_WIDTH_BITS){1'b0}}, regs.image_width};
    if (w_ext < 32'd3) begin
      w_eff = 32'd3;
    end else if (w_ext > 32'(MAX_WIDTH)) begin
      w_eff = 32'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    w_last_full = w_eff - 32'd1;
    w_last      = w_last_full[CW-1:0];
    h_eff  = (regs.image_height < 16'd3) ? 16'd3 : regs.image_height;
    h_last = h_eff - 16'd1;
  end

  // Hand a word to the second stage when it is empty or moving on
  assign b_adv    = b_valid_r && (!b_emit_r || out_free);
  assign in_ready = !b_valid_r || b_adv;
  assign accept   = in_valid && in_ready;

  assign pix_ext = {{(16-PIXEL_IN_BITS){1'b0}}, in_data.pixel};
  assign pix_in  = pix_ext[PB-1:0];

  // Advance the raster position
  always_comb begin
    col_cur = in_data.frame_start ? '0 : col_r;
    row_cur = in_data.frame_start ? '0 : row_r;
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_cur >= w_last) begin
        col_nxt = '0;
        row_nxt = (row_cur >= h_last) ? '0 : row_cur + 16'd1;
      end else begin
        col_nxt = col_cur + CW'(1);
        row_nxt = row_cur;
      end
    end
  end

  always_comb begin
    b_valid_nxt = b_valid_r;
    if (accept) begin
      b_valid_nxt = 1'b1;
    end else if (b_adv) begin
      b_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      b_valid_r <= 1'b0;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      b_emit_r <= (row_cur >= 16'd2) && (col_cur >= CW'(2));
      b_last_r <= (row_cur == h_last) && (col_cur == w_last);
      b_idx_r  <= col_cur;
      b_px_r   <= pix_in;
    end
  end

  // Row two above and row one above
  lap3_line_store #(.DEPTH(MAX_WIDTH), .WIDTH(PB)) u_upper (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_cur),
    .rd_data (up_rd),
    .wr_en   (b_adv),
    .wr_addr (b_idx_r),
    .wr_data (lo_rd)
  );

  lap3_line_store #(.DEPTH(MAX_WIDTH), .WIDTH(PB)) u_lower (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_cur),
    .rd_data (lo_rd),
    .wr_en   (b_adv),
    .wr_addr (b_idx_r),
    .wr_data (b_px_r)
  );

  // Window columns: previous column, then the one before it
  lap3_col_cell #(.PB(PB)) u_cell0 (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (b_adv),
    .top_in   (up_rd),
    .mid_in   (lo_rd),
    .bot_in   (b_px_r),
    .top_out  (w0_top),
    .mid_out  (w0_mid),
    .bot_out  (w0_bot)
  );

  lap3_col_cell #(.PB(PB)) u_cell1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (b_adv),
    .top_in   (w0_top),
    .mid_in   (w0_mid),
    .bot_in   (w0_bot),
    .top_out  (),
    .mid_out  (w1_mid),
    .bot_out  ()
  );

  // Four times center minus the four neighbors
  assign sum = (SW'(w0_mid) << 2) - SW'(w0_top) - SW'(w0_bot) - SW'(w1_mid) - SW'(lo_rd);

  // Hold the result until taken
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = b_valid_r && b_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && b_emit_r) begin
      out_data_r.filtered <= sum[FILT_BITS-1:0];
      out_data_r.last     <= b_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== dv/tb_laplacian_3x3_stream_filter.sv =====
// Self-checking testbench for the 3x3 four-neighbor Laplacian stream filter.
`timescale 1ns / 100ps

module tb_laplacian_3x3_stream_filter;
  import lap3_pkg::*;

  localparam int LINE_DEPTH = 1024;
  localparam int CLK_HALF   = 2;
  localparam int DRAIN_GAP  = 10;

  // Predicts result words from accepted pixel words and checks the block's output
  class lap_scoreboard;
    logic [PIXEL_IN_BITS-1:0]  upper_row [LINE_DEPTH];
    logic [PIXEL_IN_BITS-1:0]  lower_row [LINE_DEPTH];
    logic [PIXEL_IN_BITS-1:0]  win [6];
    int                        col_pos;
    int                        row_pos;
    logic [CFG_WIDTH_BITS-1:0] width_reg;
    logic [CFG_HGT_BITS-1:0]   height_reg;
    out_word_t                 expected_q [$];
    int                        mismatches;
    int                        words_noted;
    int                        results_checked;
    int                        frame_ends;

    function new();
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      col_pos    = 0;
      row_pos    = 0;
      foreach (upper_row[i]) begin
        upper_row[i] = '0;
        lower_row[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      mismatches      = 0;
      words_noted     = 0;
      results_checked = 0;
      frame_ends      = 0;
    endfunction

    function void set_reg(logic [0:0] idx, logic [CFG_DATA_BITS-1:0] value);
      if (idx == REG_IMAGE_WIDTH) width_reg = value[CFG_WIDTH_BITS-1:0];
      else height_reg = value[CFG_HGT_BITS-1:0];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Advance the filter state by one pixel and queue the result it causes
    function void note_pixel(in_word_t word);
      int                       eff_w;
      int                       eff_h;
      int                       idx;
      int                       lap;
      logic [PIXEL_IN_BITS-1:0] top;
      logic [PIXEL_IN_BITS-1:0] mid;
      out_word_t                want;
      words_noted++;
      eff_w = (width_reg < 3) ? 3 : ((width_reg > LINE_DEPTH) ? LINE_DEPTH : int'(width_reg));
      eff_h = (height_reg < 3) ? 3 : int'(height_reg);
      if (word.frame_start) begin
        col_pos = 0;
        row_pos = 0;
      end
      idx = col_pos % LINE_DEPTH;
      top = upper_row[idx];
      mid = lower_row[idx];
      upper_row[idx] = mid;
      lower_row[idx] = word.pixel;
      // Window full: emit for the pixel one row up and one column left
      if (row_pos >= 2 && col_pos >= 2) begin
        lap = 4 * int'(win[4]) - int'(win[3]) - int'(win[5]) - int'(win[1]) - int'(mid);
        want.filtered = lap[FILT_BITS-1:0];
        want.last     = (row_pos == eff_h - 1) && (col_pos == eff_w - 1);
        expected_q.push_back(want);
      end
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = top;
      win[4] = mid;
      win[5] = word.pixel;
      // Wrap column at end of row, row at end of frame
      if (col_pos + 1 >= eff_w) begin
        col_pos = 0;
        row_pos = (row_pos + 1 >= eff_h) ? 0 : ((row_pos + 1) & 16'hFFFF);
      end else begin
        col_pos++;
      end
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result word: filtered=%0d last=%0b", got.filtered, got.last);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      results_checked++;
      if (want.last) frame_ends++;
      if (got.filtered !== want.filtered) begin
        $error("filtered mismatch: expected %0d, actual %0d", want.filtered, got.filtered);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last mismatch: expected %0b, actual %0b", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  in_word_t                     in_data;
  logic                         out_valid;
  logic                         out_ready;
  out_word_t                    out_data;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [CFG_ADDR_BITS-1:0]     paddr;
  logic [CFG_DATA_BITS-1:0]     pwdata;
  logic [CFG_DATA_BITS-1:0]     prdata;
  logic                         pready;

  lap_scoreboard sb;
  int            tx_idle_pct;
  int            rx_stall_pct;
  int            hold_cycles;

  laplacian_3x3_stream_filter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  // Drive out_ready at the falling edge; a long hold-off takes priority
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready = 1'b0;
        hold_cycles--;
      end else begin
        out_ready = ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Check each result word accepted at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Give up after a generous fixed time
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Offer one pixel word, with random gaps ahead of it, and hold it until taken
  task automatic send_word(in_word_t word);
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_pixel(word);
    @(negedge clk);
  endtask

  task automatic send_pixel(logic [PIXEL_IN_BITS-1:0] px, logic fs);
    in_word_t word;
    word.pixel       = px;
    word.frame_start = fs;
    send_word(word);
  endtask

  // Write a register over APB, then read it back
  task automatic write_reg(logic [0:0] idx, logic [CFG_DATA_BITS-1:0] value);
    logic [CFG_DATA_BITS-1:0] rd;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    pwrite  = 1'b1;
    psel    = 1'b1;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    sb.set_reg(idx, value);
    @(negedge clk);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (idx == REG_IMAGE_WIDTH && rd[CFG_WIDTH_BITS-1:0] !== value[CFG_WIDTH_BITS-1:0]) begin
      $error("image_width readback: expected %0d, actual %0d",
             value[CFG_WIDTH_BITS-1:0], rd[CFG_WIDTH_BITS-1:0]);
      sb.mismatches++;
    end
    if (idx == REG_IMAGE_HEIGHT && rd[CFG_HGT_BITS-1:0] !== value[CFG_HGT_BITS-1:0]) begin
      $error("image_height readback: expected %0d, actual %0d",
             value[CFG_HGT_BITS-1:0], rd[CFG_HGT_BITS-1:0]);
      sb.mismatches++;
    end
  endtask

  // Wait for the stream to drain, then let in-flight border pixels settle
  task automatic wait_idle();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  task automatic set_size(int w, int h);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  // Random pixel stream; a restart marks the first word, fs_one_in adds stray restarts
  task automatic run_phase(int n_words, bit restart, int fs_one_in, int pause_at);
    in_word_t word;
    for (int i = 0; i < n_words; i++) begin
      if (i == pause_at) begin
        in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
      end
      if ($urandom_range(7) == 0) word.pixel = $urandom_range(1) ? 8'hFF : 8'h00;
      else word.pixel = $urandom_range(255);
      word.frame_start = (i == 0 && restart) ||
                         (fs_one_in > 0 && $urandom_range(fs_one_in - 1) == 0);
      send_word(word);
    end
    in_valid = 1'b0;
  endtask

  initial begin
    sb           = new();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_cycles  = 0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Directed: sizes below range act as 3x3; extreme responses on a checkerboard
    set_size(0, 0);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        send_pixel(((r + c) % 2 == 0) ? 8'hFF : 8'h00, r == 0 && c == 0);
    // Next frame follows without a restart flag, inverted pattern
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        send_pixel(((r + c) % 2 == 0) ? 8'h00 : 8'hFF, 1'b0);
    // Partial row, then restart mid-row
    send_pixel($urandom_range(255), 1'b0);
    send_pixel($urandom_range(255), 1'b0);
    for (int k = 0; k < 9; k++) send_pixel($urandom_range(255), k == 0);
    in_valid = 1'b0;

    // No idling; long output hold-off at the start so the input backs up
    set_size(7, 5);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_cycles  = 300;
    run_phase(250, 1'b1, 80, -1);

    // Sender gaps, with one pause until every result has drained
    set_size(16, 9);
    tx_idle_pct  = 58;
    rx_stall_pct = 0;
    run_phase(250, 1'b1, 100, 120);

    // Receiver stalls on a tall frame; stop mid-frame at row 25, column 5
    set_size(12, 65535);
    tx_idle_pct  = 0;
    rx_stall_pct = 58;
    run_phase(305, 1'b1, 0, -1);

    // Shrink both sizes mid-frame and carry on without a restart
    set_size(5, 20);
    tx_idle_pct  = 18;
    rx_stall_pct = 18;
    run_phase(200, 1'b0, 0, -1);

    // Smallest width with frequent restarts
    set_size(3, 4);
    run_phase(150, 1'b1, 20, -1);

    wait_idle();
    $display("Covered %0d pixel words and %0d result words, %0d of them frame ends,",
             sb.words_noted, sb.results_checked, sb.frame_ends);
    $display("across widths 3..16, heights 3..65535, stalls, restarts and a mid-frame resize.");
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
